### hdl/ppa_pkg.sv
package ppa_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int PRE_SHIFT    = 12;
   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int XY_W         = 32;
   localparam int Z_W          = 19;
   localparam int ANGLE_W      = 16;
   localparam int TRIM_W       = 14;

   localparam logic [ANGLE_W-1:0] ANG_ZERO          = 16'd0;
   localparam logic [ANGLE_W-1:0] ANG_PI            = 16'd25736;
   localparam logic [ANGLE_W-1:0] ANG_HALF_PI       = 16'd12868;
   localparam logic [ANGLE_W-1:0] ANG_THREE_HALF_PI = 16'd38604;
   localparam logic [ANGLE_W-1:0] ANG_MAX           = 16'd51471;
   localparam logic [ANGLE_W:0]   ANG_TWO_PI        = 17'd51472;

   // atan(2^-i) in units of 2^-16 rad
   localparam logic [16:0] ATAN_TABLE [CORDIC_STEPS] = '{
      17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
      17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2
   };

   typedef struct packed {
      logic               axis;
      logic [ANGLE_W-1:0] axis_angle;
      logic               dx_neg;
      logic               dy_neg;
   } ppa_side_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      ppa_side_type           side;
   } ppa_stage_type;

endpackage

### hdl/ppa_cordic_stage.sv
module ppa_cordic_stage
   import ppa_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  ppa_stage_type in_data,
   output logic          out_valid,
   output ppa_stage_type out_data
);

   localparam logic signed [Z_W-1:0] ANGLE_STEP =
      signed'({{(Z_W-17){1'b0}}, ATAN_TABLE[STEP]});

   logic          valid_ff;
   ppa_stage_type data_ff;
   ppa_stage_type data_in;
   logic signed [XY_W-1:0] x_shift;
   logic signed [XY_W-1:0] y_shift;

   always_comb begin
      x_shift = in_data.x >>> STEP;
      y_shift = in_data.y >>> STEP;
      data_in = in_data;
      // rotate toward the x axis
      if (!in_data.y[XY_W-1]) begin
         data_in.x = in_data.x + y_shift;
         data_in.y = in_data.y - x_shift;
         data_in.z = in_data.z + ANGLE_STEP;
      end else begin
         data_in.x = in_data.x - y_shift;
         data_in.y = in_data.y + x_shift;
         data_in.z = in_data.z - ANGLE_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/point_polar_angle.sv
// point_polar_angle
// Returns the angle of a point around a center, counter-clockwise from the
// positive x axis, as unsigned Q3.13 radians in [0, 2*pi).
// Input channel req_*: point and center coordinates, signed Q12.4. A
// transaction is taken on a rising edge with req_valid high and req_stall low.
// Result channel rsp_*: one angle per input transaction, in input order.
// From input transaction to rsp_valid: one stage forms the offsets and their
// magnitudes, sixteen stages run one CORDIC vectoring step each, one stage
// rounds and clamps the first-quadrant angle, and one stage maps it to its
// quadrant into the output register.
// Throughput: one transaction per cycle while the receiver does not stall.
// Points on an axis or at the center bypass the CORDIC result with fixed angles.
// When the receiver stalls a valid result, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipeline; there is no other state.
module point_polar_angle
   import ppa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ANGLE_W-1:0]        rsp_angle
);

   logic advance;

   logic          stage_valid [CORDIC_STEPS+1];
   ppa_stage_type stage_data  [CORDIC_STEPS+1];

   logic          entry_valid_ff;
   ppa_stage_type entry_ff;
   ppa_stage_type entry_in;

   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic [DIFF_W-1:0]        dx_mag;
   logic [DIFF_W-1:0]        dy_mag;

   logic                      trim_valid_ff;
   logic [TRIM_W-1:0]         trim_ff;
   logic [TRIM_W-1:0]         trim_in;
   ppa_side_type              trim_side_ff;
   logic signed [Z_W-1:0]     z_round;
   logic signed [Z_W-4:0]     z_scaled;

   logic               out_valid_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic [ANGLE_W-1:0] angle_in;
   logic [ANGLE_W:0]   wrap_sum;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = out_valid_ff && rsp_stall;

   // offsets, magnitudes and axis cases
   always_comb begin
      dx = DIFF_W'(req_point_x) - DIFF_W'(req_center_x);
      dy = DIFF_W'(req_point_y) - DIFF_W'(req_center_y);
      dx_mag = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      dy_mag = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

      entry_in.x = signed'({{(XY_W-DIFF_W-PRE_SHIFT){1'b0}}, dx_mag, {PRE_SHIFT{1'b0}}});
      entry_in.y = signed'({{(XY_W-DIFF_W-PRE_SHIFT){1'b0}}, dy_mag, {PRE_SHIFT{1'b0}}});
      entry_in.z = '0;
      entry_in.side.dx_neg = dx[DIFF_W-1];
      entry_in.side.dy_neg = dy[DIFF_W-1];
      entry_in.side.axis   = (dx == '0) || (dy == '0);
      if (dx == '0) begin
         if (dy == '0) begin
            entry_in.side.axis_angle = ANG_ZERO;
         end else if (dy[DIFF_W-1]) begin
            entry_in.side.axis_angle = ANG_THREE_HALF_PI;
         end else begin
            entry_in.side.axis_angle = ANG_HALF_PI;
         end
      end else if (dx[DIFF_W-1]) begin
         entry_in.side.axis_angle = ANG_PI;
      end else begin
         entry_in.side.axis_angle = ANG_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_data[0]  = entry_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      ppa_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // round to q3.13 and clamp to the first quadrant
   always_comb begin
      z_round  = stage_data[CORDIC_STEPS].z + Z_W'(4);
      z_scaled = z_round[Z_W-1:3];
      if (z_scaled[Z_W-4]) begin
         trim_in = '0;
      end else if (z_scaled > signed'(ANG_HALF_PI)) begin
         trim_in = ANG_HALF_PI[TRIM_W-1:0];
      end else begin
         trim_in = z_scaled[TRIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_valid_ff <= 1'b0;
      end else if (advance) begin
         trim_valid_ff <= stage_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trim_ff      <= trim_in;
         trim_side_ff <= stage_data[CORDIC_STEPS].side;
      end
   end

   // quadrant mapping
   always_comb begin
      wrap_sum = ANG_TWO_PI - {{(ANGLE_W+1-TRIM_W){1'b0}}, trim_ff};
      if (trim_side_ff.axis) begin
         angle_in = trim_side_ff.axis_angle;
      end else if (!trim_side_ff.dx_neg && !trim_side_ff.dy_neg) begin
         angle_in = {{(ANGLE_W-TRIM_W){1'b0}}, trim_ff};
      end else if (trim_side_ff.dx_neg && !trim_side_ff.dy_neg) begin
         angle_in = ANG_PI - {{(ANGLE_W-TRIM_W){1'b0}}, trim_ff};
      end else if (trim_side_ff.dx_neg) begin
         angle_in = ANG_PI + {{(ANGLE_W-TRIM_W){1'b0}}, trim_ff};
      end else if (wrap_sum > {1'b0, ANG_MAX}) begin
         angle_in = ANG_MAX;
      end else begin
         angle_in = wrap_sum[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= trim_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_angle = angle_ff;

endmodule
